### rtl/core/cpuvn_pkg.sv
// Shared types and constants for the cube face uv projection and normalizer core.
// Holds field widths, request and status codes, state encoding and the store entry layout.
// Depends on nothing; the core takes everything by scoped name.
package cpuvn_pkg;

    // Field widths
    localparam int CW        = 32;            // coordinate width, signed Q15.16
    localparam int FRAC_BITS = 16;
    localparam int UW        = FRAC_BITS + 1; // unsigned Q1.16 result width
    localparam int IDX_W     = 10;
    localparam int CNT_W     = IDX_W + 1;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;

    // Store capacity
    localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(1) << IDX_W;

    // Divider widths: divisor is 2*major (33 bits), partial remainder one more
    localparam int DW        = CW + 1;
    localparam int RW        = DW + 1;
    localparam int DIV_STEPS = UW;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Stream packing
    localparam int S_TDATA_BITS = 3 * CW + IDX_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 2 * UW + CNT_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W    = ((REQ_W + 7) / 8) * 8;
    localparam int M_TUSER_W    = ((ST_W + 7) / 8) * 8;

    localparam logic [UW-1:0] UV_ONE = UW'(1) << FRAC_BITS;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_DEGEN = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_ZSPAN = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_FACE,
        S_INIT,
        S_RDADR,
        S_RDCHK,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          degen;
        logic [UW-1:0] v;
        logic [UW-1:0] u;
    } t_entry;

endpackage

### rtl/core/cube_projection_uv_normalizer_core.sv
// Cube face uv projection with a point store and span normalization on read.
// From accept to m_axis_tvalid a load runs abs, face, init, the 17-step restoring divider (u and v
// lanes side by side) and commit, the origin point skipping the divider; a read runs address, check,
// divider and commit; a degenerate point or zero span ends after check, an out-of-range read after
// address, a load on a full store at once. One item is taken at a time; a clear returns nothing.
// Reset (i_rst_n low, synchronous) empties the count, zeroes both maxima, drops any pending
// result; the point store itself is not swept and holds stale data.
module cube_projection_uv_normalizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // x_coord[31:0], y_coord[63:32], z_coord[95:64], read_index[105:96], zero pad
    input  logic [cpuvn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type[1:0], zero pad
    input  logic [cpuvn_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // u_norm[16:0], v_norm[33:17], point_count[44:34], zero pad
    output logic [cpuvn_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // status[1:0], zero pad
    output logic [cpuvn_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    localparam int CW    = cpuvn_pkg::CW;
    localparam int UW    = cpuvn_pkg::UW;
    localparam int DW    = cpuvn_pkg::DW;
    localparam int RW    = cpuvn_pkg::RW;
    localparam int IDX_W = cpuvn_pkg::IDX_W;
    localparam int CNT_W = cpuvn_pkg::CNT_W;

    // Control
    cpuvn_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [UW-1:0]     r_max_u, r_max_v;
    logic [cpuvn_pkg::STEP_W-1:0] r_step;

    // Captured item
    logic [cpuvn_pkg::REQ_W-1:0] r_req;
    logic signed [CW-1:0]        r_x, r_y, r_z;
    logic [IDX_W-1:0]            r_idx;

    // Projection front end
    logic [CW-1:0]        r_ax, r_ay, r_az;
    logic [CW-1:0]        r_major;
    logic signed [DW-1:0] r_uc, r_vc;
    logic                 r_origin;
    logic [UW-1:0]        r_span;

    // Divider lanes
    logic [RW-1:0] r_rem_u, r_rem_v;
    logic [DW-1:0] r_div;
    logic [UW-1:0] r_qu, r_qv;

    // Result holding register and output stage
    logic [UW-1:0]               r_res_u, r_res_v;
    logic [cpuvn_pkg::ST_W-1:0]  r_res_st;
    logic [CNT_W-1:0]            r_res_cnt;
    logic                        r_m_valid;
    logic [UW-1:0]               r_m_u, r_m_v;
    logic [cpuvn_pkg::ST_W-1:0]  r_m_st;
    logic [CNT_W-1:0]            r_m_cnt;

    // Point store
    cpuvn_pkg::t_entry r_mem [cpuvn_pkg::MAX_POINTS];
    cpuvn_pkg::t_entry r_mem_q;

    logic s_acc, out_free, store_full, idx_bad, last_step, commit_load;
    logic [cpuvn_pkg::REQ_W-1:0] in_req;
    logic [UW-1:0] span_now;

    assign s_axis_tready = (r_state == cpuvn_pkg::S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser[cpuvn_pkg::REQ_W-1:0];
    assign out_free      = !r_m_valid || m_axis_tready;
    assign store_full    = (r_count >= cpuvn_pkg::MAX_POINTS);
    assign idx_bad       = ({1'b0, r_idx} >= r_count);
    assign last_step     = (r_step == cpuvn_pkg::STEP_W'(cpuvn_pkg::DIV_STEPS - 1));
    assign commit_load   = (r_state == cpuvn_pkg::S_FIN) && (r_req == cpuvn_pkg::REQ_LOAD);
    assign span_now      = (r_max_u > r_max_v) ? r_max_u : r_max_v;

    // Face selection: largest magnitude wins, ties go to the later axis
    logic                 sel_y, sel_z;
    logic                 x_pos, y_pos, z_pos;
    logic signed [DW-1:0] xe, ye, ze;
    logic [CW-1:0]        f_major;
    logic signed [DW-1:0] f_uc, f_vc;

    always_comb begin
        xe    = DW'(r_x);
        ye    = DW'(r_y);
        ze    = DW'(r_z);
        x_pos = !r_x[CW-1] && (r_x != '0);
        y_pos = !r_y[CW-1] && (r_y != '0);
        z_pos = !r_z[CW-1] && (r_z != '0);
        sel_z = (r_az >= r_ax) && (r_az >= r_ay);
        sel_y = (r_ay >= r_ax) && (r_ay >= r_az);
        if (sel_z) begin
            f_major = r_az;
            f_uc    = z_pos ? xe : -xe;
            f_vc    = ye;
        end else if (sel_y) begin
            f_major = r_ay;
            f_uc    = xe;
            f_vc    = y_pos ? -ze : ze;
        end else begin
            f_major = r_ax;
            f_uc    = x_pos ? -ze : ze;
            f_vc    = ye;
        end
    end

    // One restoring step per lane: compare, subtract, shift in one quotient bit
    logic          ge_u, ge_v;
    logic [RW-1:0] div_ext, sel_u, sel_v;

    always_comb begin
        div_ext = {1'b0, r_div};
        ge_u    = (r_rem_u >= div_ext);
        ge_v    = (r_rem_v >= div_ext);
        sel_u   = ge_u ? (r_rem_u - div_ext) : r_rem_u;
        sel_v   = ge_v ? (r_rem_v - div_ext) : r_rem_v;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpuvn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpuvn_pkg::S_IDLE: begin
                if (s_acc) begin
                    case (in_req)
                        cpuvn_pkg::REQ_LOAD: n_state = store_full ? cpuvn_pkg::S_DONE
                                                                  : cpuvn_pkg::S_ABS;
                        cpuvn_pkg::REQ_READ: n_state = cpuvn_pkg::S_RDADR;
                        default:             n_state = cpuvn_pkg::S_IDLE;
                    endcase
                end
            end
            cpuvn_pkg::S_ABS:   n_state = cpuvn_pkg::S_FACE;
            cpuvn_pkg::S_FACE:  n_state = cpuvn_pkg::S_INIT;
            cpuvn_pkg::S_INIT: begin
                n_state = (r_major == '0) ? cpuvn_pkg::S_FIN : cpuvn_pkg::S_DIV;
            end
            cpuvn_pkg::S_RDADR: begin
                n_state = idx_bad ? cpuvn_pkg::S_DONE : cpuvn_pkg::S_RDCHK;
            end
            cpuvn_pkg::S_RDCHK: begin
                n_state = (r_mem_q.degen || r_span == '0) ? cpuvn_pkg::S_DONE
                                                           : cpuvn_pkg::S_DIV;
            end
            cpuvn_pkg::S_DIV: begin
                if (last_step) begin
                    n_state = cpuvn_pkg::S_FIN;
                end
            end
            cpuvn_pkg::S_FIN:   n_state = cpuvn_pkg::S_DONE;
            cpuvn_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cpuvn_pkg::S_IDLE;
                end
            end
            default: n_state = cpuvn_pkg::S_IDLE;
        endcase
    end

    // Count, maxima, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max_u   <= '0;
            r_max_v   <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // clear restarts the store; pending output keeps its captured count
            if (s_acc && in_req == cpuvn_pkg::REQ_CLEAR) begin
                r_count <= '0;
                r_max_u <= '0;
                r_max_v <= '0;
            end
            if (commit_load) begin
                r_count <= r_count + CNT_W'(1);
                if (!r_origin && r_qu > r_max_u) begin
                    r_max_u <= r_qu;
                end
                if (!r_origin && r_qv > r_max_v) begin
                    r_max_v <= r_qv;
                end
            end
            if (r_state == cpuvn_pkg::S_DIV) begin
                r_step <= r_step + cpuvn_pkg::STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (r_state == cpuvn_pkg::S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req <= in_req;
            r_x   <= s_axis_tdata[CW-1:0];
            r_y   <= s_axis_tdata[2*CW-1:CW];
            r_z   <= s_axis_tdata[3*CW-1:2*CW];
            r_idx <= s_axis_tdata[3*CW+IDX_W-1:3*CW];
            // full store: drop the point and report it at once
            if (in_req == cpuvn_pkg::REQ_LOAD && store_full) begin
                r_res_u   <= '0;
                r_res_v   <= '0;
                r_res_st  <= cpuvn_pkg::ST_RANGE;
                r_res_cnt <= r_count;
            end
        end
        case (r_state)
            cpuvn_pkg::S_ABS: begin
                r_ax <= r_x[CW-1] ? CW'(-r_x) : CW'(r_x);
                r_ay <= r_y[CW-1] ? CW'(-r_y) : CW'(r_y);
                r_az <= r_z[CW-1] ? CW'(-r_z) : CW'(r_z);
            end
            cpuvn_pkg::S_FACE: begin
                r_major <= f_major;
                r_uc    <= f_uc;
                r_vc    <= f_vc;
            end
            cpuvn_pkg::S_INIT: begin
                // uc + major lies in [0, 2*major]; the sum is taken unsigned
                r_origin <= (r_major == '0);
                r_rem_u  <= {1'b0, DW'(r_uc + DW'(r_major))};
                r_rem_v  <= {1'b0, DW'(r_vc + DW'(r_major))};
                r_div    <= {r_major, 1'b0};
                r_qu     <= '0;
                r_qv     <= '0;
            end
            cpuvn_pkg::S_RDADR: begin
                r_span <= span_now;
                if (idx_bad) begin
                    r_res_u   <= '0;
                    r_res_v   <= '0;
                    r_res_st  <= cpuvn_pkg::ST_RANGE;
                    r_res_cnt <= r_count;
                end
            end
            cpuvn_pkg::S_RDCHK: begin
                r_res_u   <= '0;
                r_res_v   <= '0;
                r_res_cnt <= r_count;
                r_res_st  <= r_mem_q.degen ? cpuvn_pkg::ST_DEGEN : cpuvn_pkg::ST_ZSPAN;
                r_rem_u   <= RW'(r_mem_q.u);
                r_rem_v   <= RW'(r_mem_q.v);
                r_div     <= DW'(r_span);
                r_qu      <= '0;
                r_qv      <= '0;
            end
            cpuvn_pkg::S_DIV: begin
                r_rem_u <= {sel_u[RW-2:0], 1'b0};
                r_rem_v <= {sel_v[RW-2:0], 1'b0};
                r_qu    <= {r_qu[UW-2:0], ge_u};
                r_qv    <= {r_qv[UW-2:0], ge_v};
            end
            cpuvn_pkg::S_FIN: begin
                r_res_u <= r_qu;
                r_res_v <= r_qv;
                if (r_req == cpuvn_pkg::REQ_LOAD) begin
                    r_res_st  <= r_origin ? cpuvn_pkg::ST_DEGEN : cpuvn_pkg::ST_OK;
                    r_res_cnt <= r_count + CNT_W'(1);
                end else begin
                    r_res_st  <= cpuvn_pkg::ST_OK;
                    r_res_cnt <= r_count;
                end
            end
            default: begin
            end
        endcase
        // move the finished result into the output stage
        if (r_state == cpuvn_pkg::S_DONE && out_free) begin
            r_m_u   <= r_res_u;
            r_m_v   <= r_res_v;
            r_m_st  <= r_res_st;
            r_m_cnt <= r_res_cnt;
        end
    end

    // Point store: one write port at the fill position, one registered read port
    always_ff @(posedge i_clk) begin
        if (commit_load) begin
            r_mem[r_count[IDX_W-1:0]] <= '{degen: r_origin, v: r_qv, u: r_qu};
        end
        r_mem_q <= r_mem[r_idx];
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(cpuvn_pkg::M_TDATA_W - cpuvn_pkg::M_TDATA_BITS){1'b0}},
                            r_m_cnt, r_m_v, r_m_u};
    assign m_axis_tuser  = {{(cpuvn_pkg::M_TUSER_W - cpuvn_pkg::ST_W){1'b0}}, r_m_st};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpuvn_pkg::MAX_POINTS)
        else $error("point count beyond capacity");

    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_u <= cpuvn_pkg::UV_ONE && r_max_v <= cpuvn_pkg::UV_ONE)
        else $error("running maximum beyond one");

    a_uv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_u <= cpuvn_pkg::UV_ONE && r_m_v <= cpuvn_pkg::UV_ONE))
        else $error("result coordinate beyond one");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_st != cpuvn_pkg::ST_OK) |-> (r_m_u == '0 && r_m_v == '0))
        else $error("flagged result carries nonzero coordinates");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpuvn_pkg::S_DIV) |-> (r_step < cpuvn_pkg::STEP_W'(cpuvn_pkg::DIV_STEPS)))
        else $error("divider ran past its last step");

endmodule

### tb/cube_projection_uv_normalizer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for cube_projection_uv_normalizer_core: directed table, then random loads,
// reads and clears, each reply checked against a cube-face projection predictor kept here.
// Depends on cpuvn_pkg and the core RTL only.
module cube_projection_uv_normalizer_core_tb;

    localparam int CW        = cpuvn_pkg::CW;
    localparam int FRAC_BITS = cpuvn_pkg::FRAC_BITS;
    localparam int UW        = cpuvn_pkg::UW;
    localparam int IDX_W     = cpuvn_pkg::IDX_W;
    localparam int CNT_W     = cpuvn_pkg::CNT_W;
    localparam int REQ_W     = cpuvn_pkg::REQ_W;
    localparam int ST_W      = cpuvn_pkg::ST_W;
    localparam int S_TDATA_W = cpuvn_pkg::S_TDATA_W;
    localparam int S_TUSER_W = cpuvn_pkg::S_TUSER_W;
    localparam int M_TDATA_W = cpuvn_pkg::M_TDATA_W;
    localparam int M_TUSER_W = cpuvn_pkg::M_TUSER_W;

    localparam logic [CNT_W-1:0] MAX_POINTS = cpuvn_pkg::MAX_POINTS;
    localparam logic [REQ_W-1:0] REQ_LOAD   = cpuvn_pkg::REQ_LOAD;
    localparam logic [REQ_W-1:0] REQ_READ   = cpuvn_pkg::REQ_READ;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = cpuvn_pkg::REQ_CLEAR;
    localparam logic [ST_W-1:0]  ST_OK      = cpuvn_pkg::ST_OK;
    localparam logic [ST_W-1:0]  ST_DEGEN   = cpuvn_pkg::ST_DEGEN;
    localparam logic [ST_W-1:0]  ST_RANGE   = cpuvn_pkg::ST_RANGE;
    localparam logic [ST_W-1:0]  ST_ZSPAN   = cpuvn_pkg::ST_ZSPAN;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;   // unused code, the core ignores it
    localparam int LIMIT_CYCLES = 400_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int MIXED_ITEMS  = 290;
    localparam int FULL_EXTRA   = 24;
    localparam int MODE_SPAN    = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN    = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_gap_mode;

    typedef struct {
        logic [UW-1:0]    u;
        logic [UW-1:0]    v;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
    } t_reply;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [CW-1:0]    z;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_reply           rep;
    } t_row;

    // clock, reset and stream signals
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_valid  = 1'b0;
    logic                 s_ready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_valid;
    logic                 m_ready  = 1'b0;

    t_gap_mode gap_mode = IDLE_NONE;

    // receiver hold-off: the stimulus bumps hold_req_cnt, the receiver serves it
    int unsigned hold_req_cnt = 0;
    int unsigned hold_served  = 0;
    int unsigned hold_left    = 0;

    // predictor state: projected store, count and running peaks
    logic [UW-1:0]    proj_u     [1024];
    logic [UW-1:0]    proj_v     [1024];
    bit               proj_degen [1024];
    logic [CNT_W-1:0] pt_count;
    logic [UW-1:0]    peak_u;
    logic [UW-1:0]    peak_v;

    t_reply pending_replies[$];
    t_row   dir_rows[$];

    int unsigned cycle_cnt  = 0;
    int unsigned fail_cnt   = 0;
    int unsigned mism_cnt   = 0;
    int unsigned reply_cnt  = 0;
    int unsigned n_load     = 0;
    int unsigned n_read     = 0;
    int unsigned n_clear    = 0;
    int unsigned n_full     = 0;
    int unsigned n_degen    = 0;
    int unsigned n_zspan    = 0;
    int unsigned n_range    = 0;
    int unsigned rand_items = 0;

    cube_projection_uv_normalizer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop in case the handshake hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, pending_replies.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Project a point onto its cube face. The later axis wins ties, zero counts as
    // negative. Returns 0 for the origin.
    function automatic bit face_project(input logic signed [CW-1:0] x, y, z,
                                        output logic [UW-1:0] pu, output logic [UW-1:0] pv);
        longint sx, sy, sz, ax, ay, az, maj, uc, vc;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        maj = 0;
        uc  = 0;
        vc  = 0;
        if (ax >= ay && ax >= az) begin
            maj = ax;
            uc  = (sx > 0) ? -sz : sz;
            vc  = sy;
        end
        if (ay >= ax && ay >= az) begin
            maj = ay;
            uc  = sx;
            vc  = (sy > 0) ? -sz : sz;
        end
        if (az >= ax && az >= ay) begin
            maj = az;
            uc  = (sz > 0) ? sx : -sx;
            vc  = sy;
        end
        if (maj == 0) begin
            pu = '0;
            pv = '0;
            return 1'b0;
        end
        pu = UW'(((uc + maj) * 65536) / (2 * maj));
        pv = UW'(((vc + maj) * 65536) / (2 * maj));
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a reply is due.
    function automatic bit predict_reply(input logic [REQ_W-1:0] req,
                                         input logic [CW-1:0] x, y, z,
                                         input logic [IDX_W-1:0] idx, output t_reply r);
        logic [UW-1:0] pu, pv, span;
        logic [63:0]   num_u, num_v;
        bit            ok;
        r = '{u: '0, v: '0, status: ST_OK, count: '0};
        case (req)
            REQ_LOAD: begin
                n_load++;
                if (pt_count >= MAX_POINTS) begin
                    n_full++;
                    r.status = ST_RANGE;
                end else begin
                    ok = face_project(x, y, z, pu, pv);
                    proj_u[pt_count]     = pu;
                    proj_v[pt_count]     = pv;
                    proj_degen[pt_count] = !ok;
                    pt_count++;
                    if (ok) begin
                        if (pu > peak_u) peak_u = pu;
                        if (pv > peak_v) peak_v = pv;
                        r.u = pu;
                        r.v = pv;
                    end else begin
                        n_degen++;
                        r.status = ST_DEGEN;
                    end
                end
            end
            REQ_READ: begin
                n_read++;
                span = (peak_u > peak_v) ? peak_u : peak_v;
                if (CNT_W'(idx) >= pt_count) begin
                    n_range++;
                    r.status = ST_RANGE;
                end else if (proj_degen[idx]) begin
                    n_degen++;
                    r.status = ST_DEGEN;
                end else if (span == 0) begin
                    n_zspan++;
                    r.status = ST_ZSPAN;
                end else begin
                    num_u = 64'(proj_u[idx]) << FRAC_BITS;
                    num_v = 64'(proj_v[idx]) << FRAC_BITS;
                    r.u   = UW'(num_u / 64'(span));
                    r.v   = UW'(num_v / 64'(span));
                end
            end
            REQ_CLEAR: begin
                n_clear++;
                pt_count = '0;
                peak_u   = '0;
                peak_v   = '0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        r.count = pt_count;
        return 1'b1;
    endfunction

    function automatic int pct_for(input t_gap_mode mode, input t_gap_mode side);
        if (mode == side) return 63;
        if (mode == IDLE_BOTH) return 35;
        return 0;
    endfunction

    function automatic t_row mk_row(input logic [REQ_W-1:0] req, input logic [CW-1:0] x, y, z,
                                    input logic [IDX_W-1:0] idx, input bit typed,
                                    input logic [UW-1:0] eu, ev, input logic [ST_W-1:0] est,
                                    input logic [CNT_W-1:0] ecnt);
        t_row r;
        r.req = req;
        r.x   = x;
        r.y   = y;
        r.z   = z;
        r.idx = idx;
        r.typed = typed;
        r.rep = '{u: eu, v: ev, status: est, count: ecnt};
        return r;
    endfunction

    // Append a row to the directed table.
    function automatic void add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Append an expected reply behind the ones still outstanding.
    function automatic void queue_reply(input t_reply r);
        pending_replies.insert(pending_replies.size(), r);
    endfunction

    // Offer one item, hold it until accepted, then predict and optionally idle.
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [CW-1:0] x, y, z,
                             input logic [IDX_W-1:0] idx, input bit typed, input t_reply typed_rep);
        logic [S_TDATA_W-1:0] word;
        logic [S_TUSER_W-1:0] user;
        t_reply               r;
        int                   gap;
        int                   pct;
        word = '0;
        word[CW-1:0]               = x;
        word[2*CW-1:CW]            = y;
        word[3*CW-1:2*CW]          = z;
        word[3*CW+IDX_W-1:3*CW]    = idx;
        user = '0;
        user[REQ_W-1:0] = req;
        s_tdata <= word;
        s_tuser <= user;
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        if (predict_reply(req, x, y, z, idx, r)) begin
            if (typed) r = typed_rep;
            queue_reply(r);
        end
        // keep offering while the receiver is held off so the core backs up
        gap = 0;
        pct = (hold_left != 0) ? 0 : pct_for(gap_mode, IDLE_SEND);
        while (gap < 40 && $urandom_range(99) < pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random coordinates: full range, small values, axis ties, extremes and zeros.
    task automatic pick_point(output logic [CW-1:0] x, y, z);
        int            sel;
        int            k;
        logic [CW-1:0] m;
        logic [CW-1:0] ext [5];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        sel = $urandom_range(99);
        x = $urandom;
        y = $urandom;
        z = $urandom;
        if (sel < 20) begin
            x = CW'(int'($urandom_range(16)) - 8);
            y = CW'(int'($urandom_range(16)) - 8);
            z = CW'(int'($urandom_range(16)) - 8);
            if ($urandom_range(1) == 1) begin
                x = x << FRAC_BITS;
                y = y << FRAC_BITS;
                z = z << FRAC_BITS;
            end
        end else if (sel < 40) begin
            m = $urandom >> $urandom_range(31);
            k = $urandom_range(3);
            x = m >> 1;
            y = m >> 1;
            z = m >> 1;
            if (k != 1) x = ($urandom_range(1) == 1) ? -m : m;
            if (k != 2) y = ($urandom_range(1) == 1) ? -m : m;
            if (k != 0) z = ($urandom_range(1) == 1) ? -m : m;
        end else if (sel < 50) begin
            x = ext[$urandom_range(4)];
            y = ext[$urandom_range(4)];
            z = ext[$urandom_range(4)];
        end else if (sel < 60) begin
            k = $urandom_range(5);
            if (k == 0 || k == 3) x = '0;
            if (k == 1 || k == 4) y = '0;
            if (k == 2 || k == 5) z = '0;
            if (k == 3) y = '0;
            if (k == 4) z = '0;
            if (k == 5) x = '0;
        end
    endtask

    // Mostly indices that hold a point, now and then anything in the field.
    function automatic logic [IDX_W-1:0] pick_index();
        if (pt_count != 0 && $urandom_range(99) < 80)
            return IDX_W'($urandom_range(int'(pt_count) - 1));
        return IDX_W'($urandom_range(1023));
    endfunction

    // Receiver: check each accepted reply, then decide tready for the next edge.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reply_cnt++;
                got.u      = m_tdata[UW-1:0];
                got.v      = m_tdata[2*UW-1:UW];
                got.count  = m_tdata[2*UW+CNT_W-1:2*UW];
                got.status = m_tuser[ST_W-1:0];
                if (pending_replies.size() == 0) begin
                    fail_cnt++;
                    mism_cnt++;
                    if (mism_cnt <= MAX_SHOWN)
                        $display("unexpected reply: u=%0d v=%0d status=%0d count=%0d",
                                 got.u, got.v, got.status, got.count);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.u !== want.u || got.v !== want.v ||
                        got.status !== want.status || got.count !== want.count) begin
                        fail_cnt++;
                        mism_cnt++;
                        if (mism_cnt <= MAX_SHOWN)
                            $display("reply %0d mismatch: expected u=%0d v=%0d st=%0d cnt=%0d, %s",
                                     reply_cnt, want.u, want.v, want.status, want.count,
                                     $sformatf("got u=%0d v=%0d st=%0d cnt=%0d",
                                               got.u, got.v, got.status, got.count));
                    end
                end
            end
            if (hold_req_cnt != hold_served) begin
                hold_served <= hold_req_cnt;
                hold_left   <= HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= pct_for(gap_mode, IDLE_RECV));
            end
        end
    end

    // Stimulus
    initial begin
        logic [CW-1:0]    x, y, z;
        logic [IDX_W-1:0] idx;
        logic [REQ_W-1:0] req;
        t_reply           none;
        int               sel;
        int               extra;
        int               fill_items;

        none       = '{u: '0, v: '0, status: ST_OK, count: '0};
        pt_count   = '0;
        peak_u     = '0;
        peak_v     = '0;
        for (int i = 0; i < 1024; i++) begin
            proj_u[i]     = '0;
            proj_v[i]     = '0;
            proj_degen[i] = 1'b0;
        end

        // Directed rows: empty store, origin, zero span, face and tie cases, extremes.
        add_row(mk_row(REQ_READ, 0, 0, 0, 0, 1, 0, 0, ST_RANGE, 0));
        add_row(mk_row(REQ_LOAD, 0, 0, 0, 0, 1, 0, 0, ST_DEGEN, 1));
        add_row(mk_row(REQ_READ, 0, 0, 0, 0, 1, 0, 0, ST_DEGEN, 1));
        // lands at the face corner: u = v = 0 keeps both peaks at zero
        add_row(mk_row(REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 1, 1, 0, 0, ST_ZSPAN, 2));
        add_row(mk_row(REQ_READ, 0, 0, 0, 2, 1, 0, 0, ST_RANGE, 2));
        add_row(mk_row(REQ_LOAD, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 0, 32'h8000_0000, 5, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 0, 0, 32'hFFFF_FFF9, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 5, 32'hFFFF_FFFB, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 32'hFFFF_FFFD, 2, 32'hFFFF_FFFD, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 6, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 9, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 0, 1, 0, 0, ST_DEGEN, 11));
        add_row(mk_row(REQ_READ, 0, 0, 0, 10'h3FF, 1, 0, 0, ST_RANGE, 11));
        add_row(mk_row(REQ_NONE, '1, '1, '1, 10'h3FF, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_CLEAR, '1, '1, '1, 10'h3FF, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 0, 1, 0, 0, ST_RANGE, 0));
        add_row(mk_row(REQ_LOAD, 32'h0001_2345, 32'hFFFE_0000, 32'h0003_0000,
                       0, 0, 0, 0, 0, 0));
        add_row(mk_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        // hold reset low at the start, then release it once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                      dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].rep);

        // Mixed traffic: loads, reads, rare clears, and ignored codes as noise.
        while (rand_items < MIXED_ITEMS) begin
            gap_mode <= t_gap_mode'((rand_items / MODE_SPAN) % 4);
            pick_point(x, y, z);
            sel = $urandom_range(99);
            if (sel < 48) begin
                req = REQ_LOAD;
                idx = IDX_W'($urandom);
            end else if (sel < 88) begin
                req = REQ_READ;
                idx = pick_index();
            end else if (sel < 93) begin
                req = REQ_CLEAR;
                idx = IDX_W'($urandom);
            end else begin
                req = REQ_NONE;
                idx = IDX_W'($urandom);
            end
            if (req != REQ_NONE) rand_items++;
            send_item(req, x, y, z, idx, 1'b0, none);
        end

        // Fill run: clear, then load until the store is full and keep loading past it
        // so dropped loads show up; sprinkle reads throughout.
        pick_point(x, y, z);
        send_item(REQ_CLEAR, x, y, z, IDX_W'($urandom), 1'b0, none);
        rand_items++;
        extra      = 0;
        fill_items = 0;
        while (extra < FULL_EXTRA) begin
            gap_mode <= t_gap_mode'((rand_items / MODE_SPAN) % 4);
            // long receiver hold-off early in the run, with the sender still pushing
            if (fill_items == 60) hold_req_cnt <= hold_req_cnt + 1;
            pick_point(x, y, z);
            if ($urandom_range(99) < 6) begin
                req = REQ_READ;
                idx = pick_index();
            end else begin
                req = REQ_LOAD;
                idx = IDX_W'($urandom);
            end
            if (pt_count >= MAX_POINTS) extra++;
            send_item(req, x, y, z, idx, 1'b0, none);
            rand_items++;
            fill_items++;
        end

        s_valid  <= 1'b0;
        gap_mode <= IDLE_NONE;

        // drain, then give the core time to push out anything stray
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) fail_cnt++;

        $display("covered %0d loads (%0d on a full store), %0d reads, %0d clears",
                 n_load, n_full, n_read, n_clear);
        $display("replies checked %0d: %0d degenerate, %0d zero span, %0d out of range",
                 reply_cnt, n_degen, n_zspan, n_range);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures (%0d mismatches)", fail_cnt, mism_cnt);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
